// ===== rtl/b64sc_pkg.sv =====
package b64sc_pkg;

    localparam logic       CFG_ENABLE    = 1'b0;
    localparam logic       CFG_DIRECTION = 1'b1;
    localparam logic [7:0] PAD_CHAR      = 8'h3D;

    typedef struct packed {
        logic        is_chars;
        logic [23:0] value;
        logic [2:0]  count;
        logic [1:0]  pads;
    } t_job;

    function automatic logic [7:0] enc_char(input logic [5:0] v);
        logic [7:0] w;
        begin
            w = {2'b00, v};
            if (v < 6'd26) begin
                enc_char = 8'd65 + w;
            end else if (v < 6'd52) begin
                enc_char = 8'd71 + w;
            end else if (v < 6'd62) begin
                enc_char = w - 8'd4;
            end else if (v == 6'd62) begin
                enc_char = 8'h2B;
            end else begin
                enc_char = 8'h2F;
            end
        end
    endfunction

    function automatic logic [6:0] dec_char(input logic [7:0] c);
        logic [7:0] t;
        begin
            t = 8'd0;
            dec_char = 7'd0;
            if (c >= 8'd65 && c <= 8'd90) begin
                t = c - 8'd65;
                dec_char = {1'b1, t[5:0]};
            end else if (c >= 8'd97 && c <= 8'd122) begin
                t = c - 8'd71;
                dec_char = {1'b1, t[5:0]};
            end else if (c >= 8'd48 && c <= 8'd57) begin
                t = c + 8'd4;
                dec_char = {1'b1, t[5:0]};
            end else if (c == 8'h2B) begin
                dec_char = {1'b1, 6'd62};
            end else if (c == 8'h2F) begin
                dec_char = {1'b1, 6'd63};
            end
        end
    endfunction

endpackage

// ===== rtl/b64sc_front.sv =====
module b64sc_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_data_byte,
    input  logic              i_flush,
    input  logic              i_enable,
    input  logic              i_direction,
    output logic              o_push,
    output b64sc_pkg::t_job   o_job
);
    import b64sc_pkg::*;

    logic [23:0] r_value, n_value;
    logic [1:0]  r_rank, n_rank;
    logic [2:0]  r_pad, n_pad;
    logic [6:0]  dec;
    logic [23:0] addend;
    logic [2:0]  flush_cnt;
    logic [2:0]  group_cnt;
    logic [2:0]  pad_upd;

    always_comb begin
        dec       = dec_char(i_data_byte);
        addend    = 24'd0;
        flush_cnt = 3'd0;
        group_cnt = 3'd0;
        pad_upd   = r_pad;
        n_value   = r_value;
        n_rank    = r_rank;
        n_pad     = r_pad;
        o_push    = 1'b0;
        o_job     = '0;
        if (i_accept) begin
            if (!i_enable) begin
                if (!i_flush) begin
                    o_push      = 1'b1;
                    o_job.value = {i_data_byte, 16'h0000};
                    o_job.count = 3'd1;
                end
            end else if (i_flush) begin
                if (!i_direction) begin
                    if (r_value != 24'd0 || r_rank != 2'd0) begin
                        o_push         = 1'b1;
                        o_job.is_chars = 1'b1;
                        o_job.value    = r_value;
                        o_job.count    = 3'd4;
                        o_job.pads     = 2'd3 - r_rank;
                        n_value        = 24'd0;
                        n_rank         = 2'd0;
                    end
                end else if (r_value != 24'd0 || r_rank != 2'd0 || r_pad != 3'd0) begin
                    flush_cnt = {1'b0, r_rank} - 3'd1 - r_pad;
                    if ({2'b00, r_rank} >= {1'b0, r_pad} + 4'd2) begin
                        o_push      = 1'b1;
                        o_job.value = r_value;
                        o_job.count = flush_cnt;
                    end
                    n_value = 24'd0;
                    n_rank  = 2'd0;
                    n_pad   = 3'd0;
                end
            end else if (!i_direction) begin
                case (r_rank)
                    2'd0:    addend = {i_data_byte, 16'h0000};
                    2'd1:    addend = {8'h00, i_data_byte, 8'h00};
                    default: addend = {16'h0000, i_data_byte};
                endcase
                n_value = r_value + addend;
                if (r_rank >= 2'd2) begin
                    o_push         = 1'b1;
                    o_job.is_chars = 1'b1;
                    o_job.value    = n_value;
                    o_job.count    = 3'd4;
                    n_value        = 24'd0;
                    n_rank         = 2'd0;
                end else begin
                    n_rank = r_rank + 2'd1;
                end
            end else if (dec[6] || i_data_byte == PAD_CHAR) begin
                if (dec[6]) begin
                    case (r_rank)
                        2'd0:    addend = {dec[5:0], 18'd0};
                        2'd1:    addend = {6'd0, dec[5:0], 12'd0};
                        2'd2:    addend = {12'd0, dec[5:0], 6'd0};
                        default: addend = {18'd0, dec[5:0]};
                    endcase
                end else if (r_pad != 3'd7) begin
                    pad_upd = r_pad + 3'd1;
                end
                n_value = r_value + addend;
                n_pad   = pad_upd;
                if (r_rank == 2'd3) begin
                    group_cnt = 3'd3 - pad_upd;
                    if (pad_upd < 3'd3) begin
                        o_push      = 1'b1;
                        o_job.value = n_value;
                        o_job.count = group_cnt;
                    end
                    n_value = 24'd0;
                    n_rank  = 2'd0;
                    n_pad   = 3'd0;
                end else begin
                    n_rank = r_rank + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value <= 24'd0;
            r_rank  <= 2'd0;
            r_pad   <= 3'd0;
        end else begin
            r_value <= n_value;
            r_rank  <= n_rank;
            r_pad   <= n_pad;
        end
    end

endmodule

// ===== rtl/b64sc_queue.sv =====
module b64sc_queue #(
    parameter int DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  b64sc_pkg::t_job   i_job,
    input  logic              i_pop,
    output b64sc_pkg::t_job   o_head,
    output logic              o_empty,
    output logic              o_full
);
    import b64sc_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_count, n_count;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    assign o_head  = r_mem[r_rd];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CW'(DEPTH));

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count < CW'(DEPTH)))
        else $error("Job pushed into a full queue.");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("Job popped from an empty queue.");

endmodule

// ===== rtl/b64sc_back.sv =====
module b64sc_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  b64sc_pkg::t_job   i_head,
    input  logic              i_empty,
    output logic              o_pop,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output logic [7:0]        o_out_byte,
    output logic              o_last
);
    import b64sc_pkg::*;

    logic [1:0] r_idx, n_idx;
    logic       r_out_valid, n_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_last;
    logic       load;
    logic [5:0] sixbit;
    logic [7:0] cur_byte;
    logic       cur_last;
    logic [2:0] pad_sum;

    always_comb begin
        case (r_idx)
            2'd0:    sixbit = i_head.value[23:18];
            2'd1:    sixbit = i_head.value[17:12];
            2'd2:    sixbit = i_head.value[11:6];
            default: sixbit = i_head.value[5:0];
        endcase
        pad_sum = {1'b0, r_idx} + {1'b0, i_head.pads};
        if (i_head.is_chars) begin
            cur_byte = (pad_sum >= 3'd4) ? PAD_CHAR : enc_char(sixbit);
        end else begin
            case (r_idx)
                2'd0:    cur_byte = i_head.value[23:16];
                2'd1:    cur_byte = i_head.value[15:8];
                default: cur_byte = i_head.value[7:0];
            endcase
        end
        cur_last = (({1'b0, r_idx} + 3'd1) == i_head.count);
        load     = !i_empty && (!r_out_valid || !i_out_stall);
        o_pop    = load && cur_last;
        n_idx    = r_idx;
        if (load) begin
            n_idx = cur_last ? 2'd0 : r_idx + 2'd1;
        end
        n_out_valid = r_out_valid;
        if (load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_byte <= cur_byte;
            r_out_last <= cur_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_last      = r_out_last;

    a_idx_in_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_empty |-> (({1'b0, r_idx} + 3'd1) <= i_head.count))
        else $error("Result index runs past the end of its job.");

    a_idx_rewinds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_idx == 2'd0))
        else $error("Result index not cleared after the final result of a job.");

endmodule

// ===== rtl/base64_stream_codec.sv =====
// Streaming base64 coder with the standard alphabet, one byte or character per input
// transaction. An input transaction is taken in every cycle while the internal job
// queue (QUEUE_DEPTH entries) has room; each one yields between zero and four result
// transactions, which leave through a single registered output at one per cycle while
// the output is not stalled, so the output port sets the sustained rate: encoding gives
// four characters for every three bytes, decoding at most three bytes for four characters
// and pass-through one byte per cycle. The first result of a transaction is written into
// the job queue at the edge at which it is taken, and from there into the output register.
// Configuration writes are always ready and should be made only while the block is idle.
module base64_stream_codec #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_flush,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_last,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_index,
    input  logic       i_cfg_data
);
    import b64sc_pkg::*;

    logic r_enable;
    logic r_direction;
    logic accept;
    logic push;
    logic pop;
    logic empty;
    logic full;
    t_job job;
    t_job head;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = full;
    assign accept      = i_in_valid && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable    <= 1'b0;
            r_direction <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ENABLE:    r_enable    <= i_cfg_data;
                CFG_DIRECTION: r_direction <= i_cfg_data;
                default:       r_enable    <= r_enable;
            endcase
        end
    end

    b64sc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (i_data_byte),
        .i_flush     (i_flush),
        .i_enable    (r_enable),
        .i_direction (r_direction),
        .o_push      (push),
        .o_job       (job)
    );

    b64sc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (empty),
        .o_full  (full)
    );

    b64sc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_empty     (empty),
        .o_pop       (pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_byte  (o_out_byte),
        .o_last      (o_last)
    );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import b64sc_pkg::*;

    localparam int           RAND_ITEMS    = 230;
    localparam int           SETTLE_CYCLES = 16;
    localparam int           CYCLE_LIMIT   = 300000;
    localparam logic [511:0] ALPHABET      =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind   kind;
        logic [7:0]  data;
        logic        flush;
        logic        cfg_idx;
        int          n_typed;
        logic [31:0] typed;
    } t_row;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_out_beat;

    logic       i_clk;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic [7:0] i_data_byte = 8'h00;
    logic       i_flush     = 1'b0;
    logic       i_out_stall = 1'b0;
    logic       i_cfg_valid = 1'b0;
    logic       i_cfg_index = 1'b0;
    logic       i_cfg_data  = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic [7:0] o_out_byte;
    logic       o_last;
    logic       o_cfg_ready;

    logic        pr_enable = 1'b0;
    logic        pr_decode = 1'b0;
    logic [23:0] pr_group  = 24'h0;
    int          pr_rank   = 0;
    int          pr_pads   = 0;

    t_out_beat   exp_q[$];
    t_row        rows[$];
    int          cur_row    = -1;
    int          n_sent     = 0;
    int          n_fail     = 0;
    int          cycles     = 0;
    int          stall_left = 0;
    bit          stall_on   = 1'b1;
    bit          idle_on    = 1'b1;
    logic        mode_en    = 1'b0;
    logic        mode_dir   = 1'b0;

    base64_stream_codec DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_data_byte (i_data_byte),
        .i_flush     (i_flush),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_byte  (o_out_byte),
        .o_last      (o_last),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    function automatic logic [7:0] b64_char(input logic [5:0] v);
        return ALPHABET[8 * (63 - int'(v)) +: 8];
    endfunction

    function automatic int b64_index(input logic [7:0] c);
        for (int k = 0; k < 64; k++) begin
            if (b64_char(6'(k)) == c) begin
                return k;
            end
        end
        return -1;
    endfunction

    function automatic int emit_chars(input logic [23:0] v, input int pads,
                                      output logic [7:0] res [4]);
        logic [5:0] sixbit;
        for (int k = 0; k < 4; k++) begin
            sixbit = 6'(v >> (18 - 6 * k));
            res[k] = (k >= 4 - pads) ? PAD_CHAR : b64_char(sixbit);
        end
        return 4;
    endfunction

    function automatic int emit_bytes(input logic [23:0] v, input int n,
                                      output logic [7:0] res [4]);
        for (int k = 0; k < n; k++) begin
            res[k] = 8'(v >> (16 - 8 * k));
        end
        return n;
    endfunction

    function automatic void clear_group();
        pr_group = 24'h0;
        pr_rank  = 0;
        pr_pads  = 0;
    endfunction

    function automatic int codec_step(input logic [7:0] b, input logic f,
                                      output logic [7:0] res [4]);
        int n;
        int idx;
        int shift;
        n = 0;
        if (!pr_enable) begin
            if (f) begin
                return 0;
            end
            res[0] = b;
            return 1;
        end
        if (f) begin
            if (!pr_decode) begin
                if (pr_group == 24'h0 && pr_rank == 0) begin
                    return 0;
                end
                n = emit_chars(pr_group, 3 - pr_rank, res);
                pr_group = 24'h0;
                pr_rank  = 0;
                return n;
            end
            if (pr_group == 24'h0 && pr_rank == 0 && pr_pads == 0) begin
                return 0;
            end
            n = pr_rank - 1 - pr_pads;
            if (n < 0) begin
                n = 0;
            end
            n = emit_bytes(pr_group, n, res);
            clear_group();
            return n;
        end
        if (!pr_decode) begin
            shift = (pr_rank < 3) ? (2 - pr_rank) * 8 : 0;
            pr_group = 24'(32'(pr_group) + (32'(b) << shift));
            pr_rank++;
            if (pr_rank >= 3) begin
                n = emit_chars(pr_group, 0, res);
                pr_group = 24'h0;
                pr_rank  = 0;
            end
            return n;
        end
        idx = b64_index(b);
        if (idx >= 0) begin
            pr_group = 24'(32'(pr_group) + (32'(idx) << ((3 - pr_rank) * 6)));
            pr_rank++;
        end else if (b == PAD_CHAR) begin
            if (pr_pads < 7) begin
                pr_pads++;
            end
            pr_rank++;
        end else begin
            return 0;
        end
        if (pr_rank >= 4) begin
            n = emit_bytes(pr_group, (pr_pads >= 3) ? 0 : 3 - pr_pads, res);
            clear_group();
        end
        return n;
    endfunction

    function automatic void add_item(input logic [7:0] b, input logic f, input int n,
                                     input logic [31:0] chars);
        rows.push_back(t_row'{kind: ROW_ITEM, data: b, flush: f, cfg_idx: 1'b0,
                              n_typed: n, typed: chars});
    endfunction

    function automatic void add_cfg(input logic idx, input logic val);
        rows.push_back(t_row'{kind: ROW_CFG, data: {7'd0, val}, flush: 1'b0, cfg_idx: idx,
                              n_typed: -1, typed: 32'h0});
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
        end else if (stall_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 10);
        end
        i_out_stall <= (stall_left > 0);
    end

    always @(posedge i_clk) begin : monitor
        logic [7:0] res [4];
        int         n;
        t_out_beat  want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_ENABLE) begin
                    pr_enable = i_cfg_data;
                end else begin
                    pr_decode = i_cfg_data;
                end
            end
            if (i_in_valid && !o_in_stall) begin
                n = codec_step(i_data_byte, i_flush, res);
                if (cur_row >= 0 && rows[cur_row].n_typed >= 0) begin
                    n = rows[cur_row].n_typed;
                    for (int k = 0; k < n; k++) begin
                        res[k] = rows[cur_row].typed[8 * (n - 1 - k) +: 8];
                    end
                end
                for (int k = 0; k < n; k++) begin
                    exp_q.push_back(t_out_beat'{data: res[k], last: (k == n - 1)});
                end
            end
            if (o_out_valid && !i_out_stall) begin
                if (exp_q.size() == 0) begin
                    $error("unexpected result: out_byte %h, last %b", o_out_byte, o_last);
                    n_fail++;
                end else begin
                    want = exp_q.pop_front();
                    if (o_out_byte !== want.data) begin
                        $error("out_byte: expected %h, actual %h", want.data, o_out_byte);
                        n_fail++;
                    end
                    if (o_last !== want.last) begin
                        $error("last: expected %b, actual %b", want.last, o_last);
                        n_fail++;
                    end
                end
            end
        end
    end

    task automatic send_item(input logic [7:0] b, input logic f, input int row);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        i_flush     <= f;
        cur_row     <= row;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        n_sent++;
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (exp_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_mode(input logic wr_en, input logic en, input logic wr_dir,
                            input logic dir);
        if (wr_en) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= CFG_ENABLE;
            i_cfg_data  <= en;
            mode_en = en;
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
        end
        if (wr_dir) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= CFG_DIRECTION;
            i_cfg_data  <= dir;
            mode_dir = dir;
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly well-formed groups; noise characters, partial groups and extra padding
    // are mixed in so that the decoder also sees broken streams.
    task automatic send_b64_group();
        int r;
        int n_pad;
        int n_chars;
        r       = $urandom_range(0, 19);
        n_pad   = (r < 12) ? 0 : (r < 15) ? 1 : (r < 18) ? 2 : $urandom_range(3, 4);
        n_chars = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 4;
        for (int k = 0; k < n_chars; k++) begin
            if ($urandom_range(0, 11) == 0) begin
                send_item(8'($urandom_range(0, 255)), 1'b0, -1);
            end
            if (k >= 4 - n_pad) begin
                send_item(PAD_CHAR, 1'b0, -1);
            end else begin
                send_item(b64_char(6'($urandom_range(0, 63))), 1'b0, -1);
            end
        end
        if (n_chars < 4 || $urandom_range(0, 7) == 0) begin
            send_item(8'($urandom_range(0, 255)), 1'b1, -1);
        end
    endtask

    initial begin : stimulus
        int  phase;
        int  quota;
        int  rand_end;
        logic [1:0] wr;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        add_item(8'h00, 1'b0, 1, 32'h00);
        add_item(8'hFF, 1'b0, 1, 32'hFF);
        add_item(8'hA5, 1'b1, 0, 32'h0);
        add_cfg(CFG_ENABLE, 1'b1);
        add_item("M", 1'b0, 0, 32'h0);
        add_item("a", 1'b0, 0, 32'h0);
        add_item("n", 1'b0, 4, "TWFu");
        add_item(8'hFF, 1'b0, 0, 32'h0);
        add_item(8'hFF, 1'b0, 0, 32'h0);
        add_item(8'hFF, 1'b0, 4, "////");
        add_item("M", 1'b0, 0, 32'h0);
        add_item(8'h00, 1'b1, 4, "TQ==");
        add_item(8'h00, 1'b1, 0, 32'h0);
        add_item(8'h00, 1'b0, 0, 32'h0);
        add_item(8'h00, 1'b1, -1, 32'h0);
        add_cfg(CFG_DIRECTION, 1'b1);
        add_item("T", 1'b0, 0, 32'h0);
        add_item("W", 1'b0, 0, 32'h0);
        add_item("F", 1'b0, 0, 32'h0);
        add_item("u", 1'b0, 3, "Man");
        add_item("*", 1'b0, 0, 32'h0);
        for (int k = 0; k < 4; k++) begin
            add_item(PAD_CHAR, 1'b0, 0, 32'h0);
        end
        add_item("Q", 1'b0, 0, 32'h0);
        add_item(8'h00, 1'b1, -1, 32'h0);
        add_item("A", 1'b0, 0, 32'h0);
        add_item("A", 1'b0, 0, 32'h0);
        add_item("A", 1'b0, 0, 32'h0);
        add_cfg(CFG_DIRECTION, 1'b0);
        add_item(8'h80, 1'b0, -1, 32'h0);

        for (int r = 0; r < rows.size(); r++) begin
            if (rows[r].kind == ROW_CFG) begin
                settle();
                set_mode(rows[r].cfg_idx == CFG_ENABLE, rows[r].data[0],
                         rows[r].cfg_idx == CFG_DIRECTION, rows[r].data[0]);
            end else begin
                send_item(rows[r].data, rows[r].flush, r);
            end
        end

        rand_end = n_sent + RAND_ITEMS;
        phase    = 0;
        while (n_sent < rand_end) begin
            settle();
            case (phase)
                0: set_mode(1'b1, 1'b0, 1'b1, 1'b0);
                1: set_mode(1'b1, 1'b1, 1'b1, 1'b0);
                2: set_mode(1'b1, 1'b1, 1'b1, 1'b1);
                default: begin
                    wr = 2'($urandom_range(1, 3));
                    set_mode(wr[0], $urandom_range(0, 4) != 0, wr[1], $urandom_range(0, 1) != 0);
                end
            endcase
            phase++;
            quota = n_sent + $urandom_range(8, 30);
            while (n_sent < quota) begin
                if (n_sent >= rand_end - 40) begin
                    idle_on  = 1'b0;
                    stall_on = 1'b0;
                end
                if (!mode_en) begin
                    send_item(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0, -1);
                end else if (!mode_dir) begin
                    send_item(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0, -1);
                end else begin
                    send_b64_group();
                end
            end
        end

        settle();
        if (n_fail == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
